FILE: rtl/wmid_pkg.sv
// ----------------------------------------------------------------------------
// wmid_pkg
// Shared types and constants of the management frame intrusion detector.
// ----------------------------------------------------------------------------
package wmid_pkg;

  localparam logic [1:0] ALERT_NONE    = 2'd0;
  localparam logic [1:0] ALERT_FLOOD   = 2'd1;
  localparam logic [1:0] ALERT_TWIN    = 2'd2;
  localparam logic [1:0] ALERT_UNKNOWN = 2'd3;

  localparam logic [3:0] SUB_DEAUTH   = 4'd12;
  localparam logic [3:0] SUB_DISASSOC = 4'd10;
  localparam logic [3:0] SUB_BEACON   = 4'd8;
  localparam logic [3:0] SUB_PROBE_RSP = 4'd5;

  localparam logic [1:0] TYPE_MGMT = 2'd0;

  localparam logic [1:0] FLAG_TWIN    = 2'b01;
  localparam logic [1:0] FLAG_UNKNOWN = 2'b10;

  localparam logic [1:0] REG_WINDOW_MS = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_UNKNOWN_EN = 2'd2;

  typedef struct packed {
    logic [11:0] frame_length;
    logic [1:0]  frame_type;
    logic [3:0]  frame_subtype;
    logic [31:0] time_ms;
    logic [47:0] bssid;
    logic        ssid_parsed;
    logic        ssid_trusted;
    logic        bssid_trusted;
  } frame_t;

  typedef struct packed {
    logic [1:0]  alert_kind;
    logic        flood_by_disassoc;
    logic [31:0] window_count;
    logic        table_full;
    logic [31:0] mgmt_count;
    logic [31:0] beacon_frames;
    logic [31:0] deauth_frames;
    logic [31:0] alert_total;
    logic [6:0]  ap_count;
  } result_t;

  // Classified work handed from the front part to the back part.
  typedef enum logic [1:0] {
    OP_IGNORE,
    OP_OTHER,
    OP_DEAUTH,
    OP_BEACON
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        disassoc;
    logic        reg_lookup;
    logic [1:0]  flag;
    logic [1:0]  kind;
    logic [31:0] time_ms;
    logic [47:0] bssid;
  } work_t;

endpackage

FILE: rtl/wmid_if.sv
// ----------------------------------------------------------------------------
// wmid_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface wmid_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/wmid_front.sv
// ----------------------------------------------------------------------------
// wmid_front
// Accepts frame digests, classifies them and pushes work into a small queue.
// ----------------------------------------------------------------------------
module wmid_front #(
  parameter int MIN_FRAME_BYTES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  wmid_pkg::frame_t   in_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               unknown_en,
  output wmid_pkg::work_t    work,
  output logic               work_valid,
  input  logic               work_ready
);
  import wmid_pkg::*;

  localparam int QDEPTH = 2;

  work_t      q [QDEPTH];
  logic       wptr, rptr;
  logic [1:0] count;
  work_t      cls;
  logic       push, pop;

  always_comb begin
    cls            = '0;
    cls.time_ms    = in_data.time_ms;
    cls.bssid      = in_data.bssid;
    cls.disassoc   = (in_data.frame_subtype == SUB_DISASSOC);
    cls.op         = OP_IGNORE;
    if (in_data.frame_length >= 12'(MIN_FRAME_BYTES) && in_data.frame_type == TYPE_MGMT) begin
      if (in_data.frame_subtype == SUB_DEAUTH || in_data.frame_subtype == SUB_DISASSOC) begin
        cls.op = OP_DEAUTH;
      end else if (in_data.frame_subtype == SUB_BEACON ||
                   in_data.frame_subtype == SUB_PROBE_RSP) begin
        cls.op = OP_BEACON;
        if (in_data.ssid_parsed) begin
          if (in_data.ssid_trusted && !in_data.bssid_trusted) begin
            cls.reg_lookup = 1'b1;
            cls.flag       = FLAG_TWIN;
            cls.kind       = ALERT_TWIN;
          end else if (!in_data.ssid_trusted && unknown_en) begin
            cls.reg_lookup = 1'b1;
            cls.flag       = FLAG_UNKNOWN;
            cls.kind       = ALERT_UNKNOWN;
          end
        end
      end else begin
        cls.op = OP_OTHER;
      end
    end
  end

  assign in_ready   = (count != 2'(QDEPTH));
  assign push       = in_valid && in_ready;
  assign work_valid = (count != 2'd0);
  assign pop        = work_valid && work_ready;
  assign work       = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cls;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/wmid_back.sv
// ----------------------------------------------------------------------------
// wmid_back
// Executes classified work: counters, flood window and the BSSID registry.
// ----------------------------------------------------------------------------
module wmid_back #(
  parameter int TABLE_ENTRIES = 96
) (
  input  logic               clk,
  input  logic               rst,
  input  wmid_pkg::work_t    work,
  input  logic               work_valid,
  output logic               work_ready,
  input  logic [15:0]        window_len,
  input  logic [15:0]        flood_threshold,
  output wmid_pkg::result_t  res,
  output logic               res_valid,
  input  logic               res_ready
);
  import wmid_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CMP, S_DONE, S_OUT} state_t;

  state_t      state;
  work_t       cur;
  // Each table word holds the alert flags above the 48-bit BSSID.
  logic [49:0] mem [TABLE_ENTRIES];
  logic [49:0] rd_word;
  logic [49:0] wr_word;
  logic        wr_en;
  logic [IW-1:0] wr_idx;
  logic [TABLE_ENTRIES-1:0] in_use;
  logic [IW-1:0] idx, cmp_idx, free_idx;
  logic        free_found, hit;
  logic [IW-1:0] hit_idx;
  logic [1:0]  hit_flags;
  logic [31:0] window_start, window_hits;
  logic        flood_reported;
  logic [31:0] cnt_mgmt, cnt_beacon, cnt_deauth, cnt_alert;
  logic [CW-1:0] used;
  logic [31:0] hits_inc;
  logic [31:0] elapsed;
  logic [1:0]  out_kind;
  logic        out_disassoc, out_full;

  assign work_ready = (state == S_IDLE) && !res_valid;
  assign hits_inc   = window_hits + 32'd1;
  assign elapsed    = work.time_ms - window_start;

  assign wr_en   = (state == S_DONE) &&
                   (hit ? ((hit_flags & cur.flag) == 2'b00) : free_found);
  assign wr_idx  = hit ? hit_idx : free_idx;
  assign wr_word = {(hit ? (hit_flags | cur.flag) : cur.flag), cur.bssid};

  always_ff @(posedge clk) begin
    rd_word <= mem[idx];
    if (wr_en) begin
      mem[wr_idx] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      res_valid      <= 1'b0;
      window_start   <= '0;
      window_hits    <= '0;
      flood_reported <= 1'b0;
      cnt_mgmt       <= '0;
      cnt_beacon     <= '0;
      cnt_deauth     <= '0;
      cnt_alert      <= '0;
      used           <= '0;
      in_use         <= '0;
      out_kind       <= ALERT_NONE;
      out_disassoc   <= 1'b0;
      out_full       <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (work_valid && work_ready) begin
            cur          <= work;
            out_kind     <= ALERT_NONE;
            out_disassoc <= 1'b0;
            out_full     <= 1'b0;
            unique case (work.op)
              OP_IGNORE: state <= S_OUT;
              OP_OTHER: begin
                cnt_mgmt <= cnt_mgmt + 32'd1;
                state    <= S_OUT;
              end
              OP_DEAUTH: begin
                cnt_mgmt   <= cnt_mgmt + 32'd1;
                cnt_deauth <= cnt_deauth + 32'd1;
                if (elapsed > {16'd0, window_len}) begin
                  window_start <= work.time_ms;
                  window_hits  <= 32'd1;
                  if (32'd1 >= {16'd0, flood_threshold}) begin
                    flood_reported <= 1'b1;
                    cnt_alert      <= cnt_alert + 32'd1;
                    out_kind       <= ALERT_FLOOD;
                    out_disassoc   <= work.disassoc;
                  end else begin
                    flood_reported <= 1'b0;
                  end
                end else begin
                  window_hits <= hits_inc;
                  if (hits_inc >= {16'd0, flood_threshold} && !flood_reported) begin
                    flood_reported <= 1'b1;
                    cnt_alert      <= cnt_alert + 32'd1;
                    out_kind       <= ALERT_FLOOD;
                    out_disassoc   <= work.disassoc;
                  end
                end
                state <= S_OUT;
              end
              OP_BEACON: begin
                cnt_mgmt   <= cnt_mgmt + 32'd1;
                cnt_beacon <= cnt_beacon + 32'd1;
                idx        <= '0;
                free_found <= 1'b0;
                hit        <= 1'b0;
                state      <= work.reg_lookup ? S_SCAN : S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        // Memory read issued for idx; compared in the next cycle, in S_CMP.
        S_SCAN: begin
          cmp_idx <= idx;
          state   <= S_CMP;
        end
        S_CMP: begin
          if (in_use[cmp_idx]) begin
            if (rd_word[47:0] == cur.bssid) begin
              hit       <= 1'b1;
              hit_idx   <= cmp_idx;
              hit_flags <= rd_word[49:48];
            end
          end else if (!free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end
          if ((in_use[cmp_idx] && rd_word[47:0] == cur.bssid) ||
              cmp_idx == IW'(TABLE_ENTRIES - 1)) begin
            state <= S_DONE;
          end else begin
            idx   <= cmp_idx + IW'(1);
            state <= S_SCAN;
          end
        end
        S_DONE: begin
          if (hit) begin
            if ((hit_flags & cur.flag) == 2'b00) begin
              cnt_alert <= cnt_alert + 32'd1;
              out_kind  <= cur.kind;
            end
          end else if (free_found) begin
            in_use[free_idx] <= 1'b1;
            used             <= used + CW'(1);
            cnt_alert        <= cnt_alert + 32'd1;
            out_kind         <= cur.kind;
          end else begin
            out_full <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res.alert_kind        = out_kind;
    res.flood_by_disassoc = out_disassoc;
    res.table_full        = out_full;
    res.window_count      = window_hits;
    res.mgmt_count        = cnt_mgmt;
    res.beacon_frames     = cnt_beacon;
    res.deauth_frames     = cnt_deauth;
    res.alert_total       = cnt_alert;
    res.ap_count          = 7'(used);
  end

endmodule

FILE: rtl/wifi_mgmt_frame_intrusion_detector.sv
// ----------------------------------------------------------------------------
// wifi_mgmt_frame_intrusion_detector
// Flags deauth floods, evil twins and unknown SSIDs from frame digests.
// ----------------------------------------------------------------------------
// One result leaves for each accepted frame digest. A frame that needs a
// registry lookup scans the BSSID memory one entry at a time, until a match
// or the last entry, through its single registered read port, reading in
// S_SCAN and comparing in S_CMP; any other frame goes straight to S_OUT. A
// two-entry queue lets new digests be accepted while the back end works.
// Registers: the flood window length at 0x0, the flood threshold at 0x4 and
// the unknown-SSID enable at 0x8. No clearing pass is needed after reset.
module wifi_mgmt_frame_intrusion_detector #(
  parameter int TABLE_ENTRIES   = 96,
  parameter int MIN_FRAME_BYTES = 24
) (
  input  logic        clk,
  input  logic        rst,
  wmid_if.sink        in_ch,
  wmid_if.source      out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wmid_pkg::*;

  logic [15:0] flood_window, flood_threshold;
  logic        unknown_en;
  work_t       work;
  logic        work_valid, work_ready;
  result_t     res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flood_window    <= 16'd1000;
      flood_threshold <= 16'd10;
      unknown_en      <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WINDOW_MS:  flood_window    <= pwdata[15:0];
        REG_THRESHOLD:  flood_threshold <= pwdata[15:0];
        REG_UNKNOWN_EN: unknown_en      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW_MS:  prdata = {16'd0, flood_window};
      REG_THRESHOLD:  prdata = {16'd0, flood_threshold};
      REG_UNKNOWN_EN: prdata = {31'd0, unknown_en};
      default:        prdata = 32'd0;
    endcase
  end

  wmid_front #(.MIN_FRAME_BYTES(MIN_FRAME_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_data    (in_ch.data),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .unknown_en (unknown_en),
    .work       (work),
    .work_valid (work_valid),
    .work_ready (work_ready)
  );

  wmid_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk             (clk),
    .rst             (rst),
    .work            (work),
    .work_valid      (work_valid),
    .work_ready      (work_ready),
    .window_len      (flood_window),
    .flood_threshold (flood_threshold),
    .res             (res),
    .res_valid       (out_ch.valid),
    .res_ready       (out_ch.ready)
  );

  assign out_ch.data = res;

endmodule

FILE: tb/sv/wmid_checker.sv
// ----------------------------------------------------------------------------
// wmid_checker
// Watches the frame and alert channels and the register port of the
// intrusion detector. Keeps its own copy of the window, counters and BSSID
// registry, predicts one result per accepted frame transaction and compares
// every result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module wmid_checker
  import wmid_pkg::*;
#(
  parameter int TABLE_ENTRIES   = 96,
  parameter int MIN_FRAME_BYTES = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  frame_t      in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  result_t     out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          results_checked,
  output int          alerts_seen,
  output int          waiting_results
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] win_len;
  logic [15:0] flood_level;
  logic        unknown_en;

  logic [31:0] win_start;
  logic [31:0] win_hits;
  logic        flood_done;
  logic [31:0] cnt_mgmt, cnt_beacon, cnt_deauth, cnt_alert;
  logic [6:0]  entries_used;
  logic [47:0] reg_addr [TABLE_ENTRIES];
  logic [1:0]  reg_flags [TABLE_ENTRIES];
  logic        reg_valid [TABLE_ENTRIES];

  result_t expected_results[$];

  assign waiting_results = expected_results.size();

  // Lookup-or-insert on the BSSID registry, then the alert raised once per BSSID for each flag.
  function automatic logic [1:0] registry_alert(input logic [47:0] addr,
                                                input logic [1:0] flag,
                                                input logic [1:0] kind,
                                                output logic full);
    int slot;
    int open_slot;
    slot = -1;
    open_slot = -1;
    full = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (reg_valid[i]) begin
        if (slot < 0 && reg_addr[i] == addr) slot = i;
      end else if (open_slot < 0) begin
        open_slot = i;
      end
    end
    if (slot < 0) begin
      if (open_slot < 0) begin
        full = 1'b1;
        return ALERT_NONE;
      end
      slot = open_slot;
      reg_addr[slot] = addr;
      reg_flags[slot] = 2'b00;
      reg_valid[slot] = 1'b1;
      entries_used++;
    end
    if ((reg_flags[slot] & flag) != 2'b00) return ALERT_NONE;
    reg_flags[slot] = reg_flags[slot] | flag;
    cnt_alert++;
    return kind;
  endfunction

  function automatic result_t predict_alert(input frame_t f);
    result_t r;
    logic full;
    r = '0;
    full = 1'b0;
    if (f.frame_length >= MIN_FRAME_BYTES && f.frame_type == TYPE_MGMT) begin
      cnt_mgmt++;
      if (f.frame_subtype == SUB_DEAUTH || f.frame_subtype == SUB_DISASSOC) begin
        cnt_deauth++;
        if (32'(f.time_ms - win_start) > {16'd0, win_len}) begin
          win_start = f.time_ms;
          win_hits = '0;
          flood_done = 1'b0;
        end
        win_hits++;
        if (win_hits >= {16'd0, flood_level} && !flood_done) begin
          flood_done = 1'b1;
          cnt_alert++;
          r.alert_kind = ALERT_FLOOD;
          r.flood_by_disassoc = (f.frame_subtype == SUB_DISASSOC);
        end
      end else if (f.frame_subtype == SUB_BEACON || f.frame_subtype == SUB_PROBE_RSP) begin
        cnt_beacon++;
        if (f.ssid_parsed) begin
          if (f.ssid_trusted && !f.bssid_trusted)
            r.alert_kind = registry_alert(f.bssid, FLAG_TWIN, ALERT_TWIN, full);
          else if (!f.ssid_trusted && unknown_en)
            r.alert_kind = registry_alert(f.bssid, FLAG_UNKNOWN, ALERT_UNKNOWN, full);
        end
      end
    end
    r.table_full    = full;
    r.window_count  = win_hits;
    r.mgmt_count    = cnt_mgmt;
    r.beacon_frames = cnt_beacon;
    r.deauth_frames = cnt_deauth;
    r.alert_total   = cnt_alert;
    r.ap_count      = entries_used;
    return r;
  endfunction

  function automatic bit same_field(input string name, input logic [63:0] exp_v,
                                    input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  initial begin
    fail_count = 0;
    results_checked = 0;
    alerts_seen = 0;
  end

  always @(posedge clk) begin
    result_t e;
    bit ok;
    if (rst) begin
      win_len = 16'd1000;
      flood_level = 16'd10;
      unknown_en = 1'b0;
      win_start = '0;
      win_hits = '0;
      flood_done = 1'b0;
      cnt_mgmt = '0;
      cnt_beacon = '0;
      cnt_deauth = '0;
      cnt_alert = '0;
      entries_used = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        reg_valid[i] = 1'b0;
        reg_flags[i] = 2'b00;
      end
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_WINDOW_MS:  win_len = pwdata[15:0];
          REG_THRESHOLD:  flood_level = pwdata[15:0];
          REG_UNKNOWN_EN: unknown_en = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result transaction with nothing expected, got 0x%0h",
                   $time, out_data);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          ok = 1'b1;
          ok &= same_field("alert_kind", e.alert_kind, out_data.alert_kind);
          ok &= same_field("flood_by_disassoc", e.flood_by_disassoc,
                           out_data.flood_by_disassoc);
          ok &= same_field("window_count", e.window_count, out_data.window_count);
          ok &= same_field("table_full", e.table_full, out_data.table_full);
          ok &= same_field("mgmt_count", e.mgmt_count, out_data.mgmt_count);
          ok &= same_field("beacon_frames", e.beacon_frames, out_data.beacon_frames);
          ok &= same_field("deauth_frames", e.deauth_frames, out_data.deauth_frames);
          ok &= same_field("alert_total", e.alert_total, out_data.alert_total);
          ok &= same_field("ap_count", e.ap_count, out_data.ap_count);
          if (!ok) fail_count++;
          if (e.alert_kind != ALERT_NONE) alerts_seen++;
          results_checked++;
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_alert(in_data));
    end
  end
endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives frame digests and register writes into the intrusion detector.
// A directed burst covers field extremes and every frame class, then random
// phases with different window, threshold and unknown-SSID settings mix
// deauth bursts, beacons from a small recurring BSSID set and fresh BSSIDs
// until the registry fills, plus malformed frames. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import wmid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_FRAMES = 1330;
  localparam int PHASES = 7;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        calm;
  int          fail_count, results_checked, alerts_seen, waiting_results;
  int          frames_sent;
  logic [31:0] now_ms;
  logic [15:0] phase_window;
  logic [47:0] bssid_pool [16];

  wmid_if #(.T(frame_t))  in_ch ();
  wmid_if #(.T(result_t)) out_ch ();

  wifi_mgmt_frame_intrusion_detector i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  wmid_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .results_checked(results_checked),
    .alerts_seen(alerts_seen), .waiting_results(waiting_results)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Holds valid high across back-to-back transactions; drops it only for a gap.
  task automatic send_frame(input frame_t f);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= f;
    do @(posedge clk); while (!in_ch.ready);
    frames_sent++;
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    int pick;
    f.frame_length = 12'($urandom_range(24, 4095));
    f.frame_type = TYPE_MGMT;
    f.time_ms = now_ms;
    f.ssid_parsed = ($urandom_range(0, 7) != 0);
    f.ssid_trusted = 1'($urandom);
    f.bssid_trusted = 1'($urandom);
    if ($urandom_range(0, 9) < 6) f.bssid = bssid_pool[$urandom_range(0, 15)];
    else f.bssid = {16'($urandom), 32'($urandom)};
    pick = $urandom_range(0, 19);
    if (pick < 7) begin
      f.frame_subtype = ($urandom_range(0, 1) != 0) ? SUB_DEAUTH : SUB_DISASSOC;
    end else if (pick < 15) begin
      f.frame_subtype = ($urandom_range(0, 1) != 0) ? SUB_BEACON : SUB_PROBE_RSP;
    end else begin
      // Malformed or uninteresting frames.
      f.frame_subtype = 4'($urandom);
      if ($urandom_range(0, 1) != 0) f.frame_type = 2'($urandom);
      if ($urandom_range(0, 2) == 0) f.frame_length = 12'($urandom_range(0, 30));
    end
    return f;
  endfunction

  function automatic frame_t make_frame(input logic [11:0] len, input logic [1:0] ftype,
                                        input logic [3:0] sub, input logic [31:0] t,
                                        input logic [47:0] addr, input logic [2:0] ssid);
    frame_t f;
    f.frame_length = len;
    f.frame_type = ftype;
    f.frame_subtype = sub;
    f.time_ms = t;
    f.bssid = addr;
    {f.ssid_parsed, f.ssid_trusted, f.bssid_trusted} = ssid;
    return f;
  endfunction

  task automatic advance_clock_ms();
    case ($urandom_range(0, 19))
      0:       now_ms = $urandom;
      1, 2:    now_ms += $urandom_range(0, 70000);
      default: now_ms += $urandom_range(0, phase_window / 6 + 1);
    endcase
  endtask

  // Receiver: random stalls, one long hold-off so the input backs up.
  initial begin
    out_ch.ready = 1'b0;
    @(negedge rst);
    repeat (150) begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    repeat (600) @(posedge clk);
    while (!calm) begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!calm) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    out_ch.ready <= 1'b1;
  end

  initial begin
    logic [15:0] win_set [PHASES];
    logic [15:0] thr_set [PHASES];
    logic        unk_set [PHASES];
    int          per_phase;
    rst = 1'b1;
    calm = 1'b0;
    frames_sent = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    now_ms = 32'hFFFF_FFF0;
    phase_window = 16'd1000;
    for (int i = 0; i < 16; i++) bssid_pool[i] = {16'($urandom), 32'($urandom)};
    bssid_pool[0] = '0;
    bssid_pool[1] = '1;
    win_set = '{16'd0, 16'd65535, 16'd50, 16'd1, 16'd300, 16'd2000, 16'd65535};
    thr_set = '{16'd0, 16'd65535, 16'd3, 16'd2, 16'd1, 16'd6, 16'd10};
    unk_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames at reset settings.
    send_frame(make_frame(12'd0, TYPE_MGMT, SUB_DEAUTH, 32'd5, '0, 3'b110));
    send_frame(make_frame(12'd23, TYPE_MGMT, SUB_BEACON, 32'd5, '1, 3'b110));
    send_frame(make_frame(12'd24, 2'd1, SUB_DEAUTH, 32'd5, '0, 3'b000));
    send_frame(make_frame(12'd4095, 2'd2, SUB_BEACON, 32'd5, '1, 3'b110));
    send_frame(make_frame(12'd100, 2'd3, SUB_DISASSOC, 32'd5, '0, 3'b111));
    send_frame(make_frame(12'd24, TYPE_MGMT, 4'd0, 32'd5, '0, 3'b111));
    send_frame(make_frame(12'd4095, TYPE_MGMT, 4'd15, '1, '1, 3'b111));
    send_frame(make_frame(12'd24, TYPE_MGMT, SUB_BEACON, 32'd10, '0, 3'b110));
    send_frame(make_frame(12'd24, TYPE_MGMT, SUB_BEACON, 32'd11, '0, 3'b110));
    send_frame(make_frame(12'd60, TYPE_MGMT, SUB_PROBE_RSP, 32'd12, '1, 3'b110));
    send_frame(make_frame(12'd60, TYPE_MGMT, SUB_PROBE_RSP, 32'd12, '1, 3'b111));
    send_frame(make_frame(12'd60, TYPE_MGMT, SUB_BEACON, 32'd12, 48'h5, 3'b101));
    send_frame(make_frame(12'd60, TYPE_MGMT, SUB_BEACON, 32'd12, 48'h6, 3'b010));
    send_frame(make_frame(12'd60, TYPE_MGMT, SUB_BEACON, 32'd12, 48'h7, 3'b100));
    for (int i = 0; i < 11; i++)
      send_frame(make_frame(12'd26, TYPE_MGMT, (i % 2 != 0) ? SUB_DISASSOC : SUB_DEAUTH,
                            32'hFFFF_FF00 + 32'(i * 40), 48'h1, 3'b000));

    per_phase = RANDOM_FRAMES / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      in_ch.valid <= 1'b0;
      // Wait for the clock edge first so the checker has queued the last accepted frame.
      @(posedge clk);
      while (waiting_results != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      write_reg(REG_WINDOW_MS, {16'($urandom), win_set[p]});
      write_reg(REG_THRESHOLD, {16'($urandom), thr_set[p]});
      write_reg(REG_UNKNOWN_EN, {31'($urandom), unk_set[p]});
      phase_window = win_set[p];
      for (int n = 0; n < per_phase; n++) begin
        if (p == PHASES - 1 && n > per_phase / 2) calm = 1'b1;
        advance_clock_ms();
        send_frame(random_frame());
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (waiting_results != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    $display("Sent %0d frame digests over %0d register settings; %0d results checked.",
             frames_sent, PHASES + 1, results_checked);
    $display("Alerts observed: %0d, registry filled with fresh BSSIDs.", alerts_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/wmid_pkg.sv
rtl/wmid_if.sv
rtl/wmid_front.sv
rtl/wmid_back.sv
rtl/wifi_mgmt_frame_intrusion_detector.sv
tb/sv/wmid_checker.sv
tb/sv/tb_top.sv
